FILE: rtl/core/dsp_pkg.sv
package dsp_pkg;

  localparam int unsigned ACC_W = 14;
  localparam int unsigned OUT_W = 24;

  localparam logic [ACC_W-1:0] ACC_MAX      = 14'd16383;
  localparam logic [ACC_W-1:0] YEAR_CAP     = 14'd9999;
  localparam logic [ACC_W-1:0] YEAR_LIM_RST = 14'd5000;
  localparam logic [ACC_W-1:0] MONTH_LAST   = 14'd12;

  localparam logic [4:0] DAYS_FEB   = 5'd29;
  localparam logic [4:0] DAYS_SHORT = 5'd30;
  localparam logic [4:0] DAYS_LONG  = 5'd31;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [2:0] IDX_MAX  = 3'd7;
  localparam logic [2:0] IDX_DATE = 3'd3;

  typedef enum logic [5:0] {
    PH_BETWEEN = 6'b000001,
    PH_LEAD    = 6'b000010,
    PH_SIGN    = 6'b000100,
    PH_DIGITS  = 6'b001000,
    PH_TRAIL   = 6'b010000,
    PH_BAD     = 6'b100000
  } phase_e;

  typedef struct packed {
    phase_e           phase;
    logic [2:0]       idx;
    logic             neg;
    logic [ACC_W-1:0] acc;
    logic [ACC_W-1:0] sday;
    logic [ACC_W-1:0] smonth;
    logic             failed;
  } parse_t;

  localparam parse_t PARSE_RST = '{
    phase:  PH_BETWEEN,
    idx:    3'd0,
    neg:    1'b0,
    acc:    '0,
    sday:   '0,
    smonth: '0,
    failed: 1'b0
  };

endpackage

FILE: rtl/core/date_string_parser_core.sv
// day/month/year date string parser and validator
//
// s_axis: one ascii byte per item in tdata, tlast marks the final byte of a
// string. tokens are split by '/', runs of '/' collapse.
// m_axis: one item per string, produced for the final byte only; tdata holds
// valid_res, day, month, year (all fields zero when the date is not valid).
// cfg: write channel for the year limit, always ready; write it only while idle.
//
// an input item is captured in an input register, parsed in the next cycle by
// the token state logic (one multiply-by-ten plus compares) and its result,
// if any, lands in the output register when the final byte leaves the input
// register, and is on m_axis from there. one byte per cycle is sustained
// while no final byte waits for the output register.
// when m_axis stalls, non-final bytes keep flowing; a final byte waits in the
// input register until the output register is free, and s_axis_tready_o
// drops only then.
// reset clears the parse state, empties both registers and sets the year
// limit to 5000.
module date_string_parser_core
  import dsp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [7:0]       s_axis_tdata_i,   // [7:0] ch
  input  logic             s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OUT_W-1:0] m_axis_tdata_o,   // [0] valid_res, [5:1] day, [9:6] month, [23:10] year
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [ACC_W-1:0] cfg_data_i
);

  logic             s1_valid_q;
  logic [7:0]       s1_ch_q;
  logic             s1_last_q;
  logic             advance;
  parse_t           st_q, st_d, st_tok, st_fin;
  logic [ACC_W-1:0] year_lim_q;
  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q, out_data_d;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {[8'h09:8'h0D], 8'h20};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic [ACC_W-1:0] add_digit(input logic [ACC_W-1:0] acc,
                                                  input logic [7:0] c);
    logic [ACC_W+3:0] v;
    v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{ACC_W{1'b0}}, c[3:0]};
    return (v > {4'd0, ACC_MAX}) ? ACC_MAX : v[ACC_W-1:0];
  endfunction

  function automatic parse_t close_token(input parse_t s);
    parse_t r;
    r = s;
    if (s.phase != PH_BETWEEN) begin
      if (s.phase == PH_SIGN || s.phase == PH_BAD) begin
        r.failed = 1'b1;
      end else if (s.neg && s.acc != '0) begin
        r.failed = 1'b1;
      end
      if (s.idx == 3'd0) begin
        r.sday = s.acc;
      end else if (s.idx == 3'd1) begin
        r.smonth = s.acc;
      end
      if (s.idx != IDX_MAX) begin
        r.idx = s.idx + 3'd1;
      end
      r.phase = PH_BETWEEN;
      r.neg   = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [4:0] days_in(input logic [ACC_W-1:0] m);
    logic [4:0] d;
    case (m)
      14'd2:                      d = DAYS_FEB;
      14'd4, 14'd6, 14'd9, 14'd11: d = DAYS_SHORT;
      default:                    d = DAYS_LONG;
    endcase
    return d;
  endfunction

  // a final byte needs room in the output register
  assign advance         = s1_valid_q && (!s1_last_q || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || advance;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      s1_ch_q   <= s_axis_tdata_i;
      s1_last_q <= s_axis_tlast_i;
    end
  end

  always_comb begin
    st_tok = st_q;
    if (s1_ch_q == CH_SLASH) begin
      st_tok = close_token(st_q);
    end else begin
      if (st_tok.phase == PH_BETWEEN) begin
        st_tok.phase = PH_LEAD;
        st_tok.acc   = '0;
        st_tok.neg   = 1'b0;
      end
      case (st_tok.phase)
        PH_LEAD: begin
          if (is_space(s1_ch_q)) begin
            st_tok.phase = PH_LEAD;
          end else if (s1_ch_q == CH_PLUS || s1_ch_q == CH_MINUS) begin
            st_tok.neg   = (s1_ch_q == CH_MINUS);
            st_tok.phase = PH_SIGN;
          end else if (is_digit(s1_ch_q)) begin
            st_tok.acc   = add_digit(st_tok.acc, s1_ch_q);
            st_tok.phase = PH_DIGITS;
          end else begin
            st_tok.phase = PH_BAD;
          end
        end
        PH_SIGN: begin
          if (is_digit(s1_ch_q)) begin
            st_tok.acc   = add_digit(st_tok.acc, s1_ch_q);
            st_tok.phase = PH_DIGITS;
          end else begin
            st_tok.phase = PH_BAD;
          end
        end
        PH_DIGITS: begin
          if (is_digit(s1_ch_q)) begin
            st_tok.acc = add_digit(st_tok.acc, s1_ch_q);
          end else if (is_space(s1_ch_q)) begin
            st_tok.phase = PH_TRAIL;
          end else begin
            st_tok.phase = PH_BAD;
          end
        end
        PH_TRAIL: begin
          if (!is_space(s1_ch_q)) begin
            st_tok.phase = PH_BAD;
          end
        end
        default: begin
          st_tok.phase = PH_BAD;
        end
      endcase
    end
    st_fin = close_token(st_tok);
    st_d   = s1_last_q ? PARSE_RST : st_tok;
  end

  // final check on the state after the last token closed
  always_comb begin
    logic [ACC_W-1:0] ylim;
    logic             ok;
    ylim = (year_lim_q > YEAR_CAP) ? YEAR_CAP : year_lim_q;
    ok   = !st_fin.failed && st_fin.idx == IDX_DATE &&
           st_fin.smonth >= 14'd1 && st_fin.smonth <= MONTH_LAST &&
           st_fin.acc >= 14'd1 && st_fin.acc <= ylim &&
           st_fin.sday >= 14'd1 &&
           st_fin.sday <= {{(ACC_W-5){1'b0}}, days_in(st_fin.smonth)};
    out_data_d = ok ? {st_fin.acc, st_fin.smonth[3:0], st_fin.sday[4:0], 1'b1}
                    : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= PARSE_RST;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_lim_q <= YEAR_LIM_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      year_lim_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_last_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // a result item appears only after a final byte was parsed
  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance && s1_last_q))
    else $error("result item without a final byte");

  // parse state starts over after each string
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(advance && s1_last_q) |-> (st_q.idx == 3'd0 && st_q.phase == PH_BETWEEN))
    else $error("parse state not cleared after final byte");

  // a held byte is neither lost nor changed
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> (s1_valid_q && $stable(s1_ch_q) && $stable(s1_last_q)))
    else $error("stalled input item lost");

  // a valid date carries plausible day and month
  a_valid_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[0]) |->
      (out_data_q[5:1] != 5'd0 && out_data_q[9:6] != 4'd0 && out_data_q[9:6] <= 4'd12))
    else $error("valid date with bad day or month");

  // an invalid date reads as all zeros
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_data_q[0]) |-> (out_data_q == '0))
    else $error("invalid date with nonzero fields");

endmodule

FILE: dv/tb_date_string_parser_core.sv
`timescale 1ns / 1ps
module tb_date_string_parser_core;
  import dsp_pkg::*;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam int unsigned HOLD_CYCLES = 120;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  // same layout as m_axis_tdata_o, valid flag in bit 0
  typedef struct packed {
    logic [ACC_W-1:0] year;
    logic [3:0]       month;
    logic [4:0]       day;
    logic             ok;
  } date_res_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [7:0]       s_axis_tdata_i = '0;
  logic             s_axis_tlast_i = 1'b0;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [ACC_W-1:0] cfg_data_i = '0;

  date_string_parser_core uut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tlast_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  char_item_t  chars_pending[$];
  date_res_t   dates_expected[$];
  logic [7:0]  str_buf[$];
  logic        in_fire = 1'b0;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;

  // parser shadow state
  phase_e           ph = PH_BETWEEN;
  logic [2:0]       tok_cnt = '0;
  logic             neg_seen = 1'b0;
  logic [ACC_W-1:0] acc_val = '0;
  logic [ACC_W-1:0] day_val = '0;
  logic [ACC_W-1:0] month_val = '0;
  logic             tok_err = 1'b0;
  logic [ACC_W-1:0] year_max = YEAR_LIM_RST;

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic [4:0] month_len(logic [ACC_W-1:0] m);
    if (m == 2) return DAYS_FEB;
    if (m == 4 || m == 6 || m == 9 || m == 11) return DAYS_SHORT;
    return DAYS_LONG;
  endfunction

  task automatic clear_parse_state();
    ph = PH_BETWEEN;
    tok_cnt = '0;
    neg_seen = 1'b0;
    acc_val = '0;
    day_val = '0;
    month_val = '0;
    tok_err = 1'b0;
  endtask

  task automatic push_digit(logic [7:0] c);
    int unsigned v;
    v = int'(acc_val) * 10 + int'(c) - int'(CH_ZERO);
    acc_val = (v > int'(ACC_MAX)) ? ACC_MAX : v[ACC_W-1:0];
  endtask

  task automatic close_tok();
    if (ph == PH_BETWEEN) return;
    if (ph == PH_SIGN || ph == PH_BAD) tok_err = 1'b1;
    else if (neg_seen && acc_val != '0) tok_err = 1'b1;
    if (tok_cnt == 3'd0) day_val = acc_val;
    else if (tok_cnt == 3'd1) month_val = acc_val;
    if (tok_cnt != IDX_MAX) tok_cnt = tok_cnt + 3'd1;
    ph = PH_BETWEEN;
    neg_seen = 1'b0;
  endtask

  task automatic parse_char(logic [7:0] c);
    if (c == CH_SLASH) begin
      close_tok();
      return;
    end
    if (ph == PH_BETWEEN) begin
      ph = PH_LEAD;
      acc_val = '0;
      neg_seen = 1'b0;
    end
    case (ph)
      PH_LEAD: begin
        if (c == CH_PLUS || c == CH_MINUS) begin
          neg_seen = (c == CH_MINUS);
          ph = PH_SIGN;
        end else if (is_num(c)) begin
          push_digit(c);
          ph = PH_DIGITS;
        end else if (!is_blank(c)) begin
          ph = PH_BAD;
        end
      end
      PH_SIGN: begin
        if (is_num(c)) begin
          push_digit(c);
          ph = PH_DIGITS;
        end else begin
          ph = PH_BAD;
        end
      end
      PH_DIGITS: begin
        if (is_num(c)) push_digit(c);
        else if (is_blank(c)) ph = PH_TRAIL;
        else ph = PH_BAD;
      end
      PH_TRAIL: begin
        if (!is_blank(c)) ph = PH_BAD;
      end
      default: ph = PH_BAD;
    endcase
  endtask

  task automatic predict_char(logic [7:0] c, logic last);
    logic [ACC_W-1:0] lim;
    date_res_t        r;
    bit               good;
    parse_char(c);
    if (!last) return;
    close_tok();
    lim = (year_max > YEAR_CAP) ? YEAR_CAP : year_max;
    good = !tok_err && tok_cnt == IDX_DATE &&
           month_val >= 1 && month_val <= MONTH_LAST &&
           acc_val >= 1 && acc_val <= lim &&
           day_val >= 1 && day_val <= month_len(month_val);
    r = '0;
    if (good) begin
      r.ok = 1'b1;
      r.day = day_val[4:0];
      r.month = month_val[3:0];
      r.year = acc_val;
    end
    dates_expected.push_back(r);
    clear_parse_state();
  endtask

  task automatic log_mismatch(string what, date_res_t want, date_res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch (%s): exp ok=%0d d=%0d m=%0d y=%0d, got ok=%0d d=%0d m=%0d y=%0d",
               $realtime, what, want.ok, want.day, want.month, want.year,
               got.ok, got.day, got.month, got.year);
  endtask

  // ---------------- string building ----------------

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
  endtask

  task automatic add_blanks(int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 5) == 5) str_buf.push_back(CH_SPACE);
      else str_buf.push_back(CH_TAB + 8'($urandom_range(0, 4)));
    end
  endtask

  task automatic add_number(int unsigned v, int unsigned zeros);
    logic [7:0] digs[$];
    repeat (zeros) str_buf.push_back(CH_ZERO);
    do begin
      digs.push_front(CH_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    str_buf = {str_buf, digs};
  endtask

  task automatic add_seps();
    str_buf.push_back(CH_SLASH);
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 2)) str_buf.push_back(CH_SLASH);
  endtask

  task automatic add_token(int unsigned v);
    int unsigned s;
    if ($urandom_range(0, 3) == 0) add_blanks($urandom_range(1, 2));
    s = $urandom_range(0, 19);
    if (s < 3) str_buf.push_back(CH_PLUS);
    else if (s == 3) str_buf.push_back(CH_MINUS);
    add_number(v, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
    if ($urandom_range(0, 4) == 0) add_blanks($urandom_range(1, 2));
  endtask

  // malformed or odd tokens
  task automatic add_junk_token();
    case ($urandom_range(0, 5))
      0: add_blanks($urandom_range(1, 3));
      1: begin
        str_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
        if ($urandom_range(0, 1)) add_blanks(1);
      end
      2: begin
        str_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
        add_blanks(1);
        add_number($urandom_range(1, 31), 0);
      end
      3: begin
        add_number($urandom_range(0, 99), 0);
        str_buf.push_back(8'($urandom_range(0, 255)));
        add_number($urandom_range(0, 9), 0);
      end
      4: begin
        add_number($urandom_range(0, 99), 0);
        add_blanks(1);
        add_number($urandom_range(0, 9), 0);
      end
      default: repeat ($urandom_range(1, 3)) str_buf.push_back(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic commit_string();
    if (str_buf.size() == 0) str_buf.push_back(8'($urandom_range(0, 255)));
    foreach (str_buf[i])
      chars_pending.push_back('{ch: str_buf[i], last: (i == str_buf.size() - 1)});
    str_buf.delete();
  endtask

  task automatic make_random_string();
    int unsigned r, m, d, y, lim, sel, bad_tok, n;
    int unsigned vals[3];
    bit          bad_on;
    r = $urandom_range(0, 99);
    if (r < 72) begin
      lim = (year_max > YEAR_CAP) ? YEAR_CAP : year_max;
      if (lim == 0) lim = YEAR_CAP;
      m = ($urandom_range(0, 99) < 88) ? $urandom_range(1, 12) : $urandom_range(0, 20);
      d = ($urandom_range(0, 99) < 80) ? $urandom_range(1, month_len(14'(m))) :
                                         $urandom_range(0, 33);
      sel = $urandom_range(0, 99);
      if (sel < 60) y = $urandom_range(1, lim);
      else if (sel < 75) y = (year_max == 0) ? $urandom_range(0, 1) :
                                               year_max + $urandom_range(0, 2) - 1;
      else if (sel < 85) y = $urandom_range(0, 99);
      else if (sel < 92) y = 0;
      else if (sel < 97) y = $urandom_range(10000, 200000);
      else y = 32'd4000000000;
      vals = '{d, m, y};
      bad_on = ($urandom_range(0, 19) == 0);
      bad_tok = $urandom_range(0, 2);
      if ($urandom_range(0, 19) == 0) add_seps();
      for (int t = 0; t < 3; t++) begin
        if (bad_on && bad_tok == t) add_junk_token();
        else add_token(vals[t]);
        if (t < 2) add_seps();
      end
      if ($urandom_range(0, 19) == 0) add_seps();
    end else if (r < 88) begin
      // wrong token count, up past saturation of the count
      n = $urandom_range(0, 1) ? $urandom_range(1, 2) : $urandom_range(4, 9);
      for (int t = 0; t < n; t++) begin
        if ($urandom_range(0, 3) == 0) add_junk_token();
        else add_token($urandom_range(0, 40));
        if (t < n - 1) add_seps();
      end
    end else begin
      repeat ($urandom_range(1, 6)) str_buf.push_back(8'($urandom_range(0, 255)));
    end
    commit_string();
  endtask

  task automatic fill_random(int unsigned n_chars);
    int unsigned target;
    target = chars_pending.size() + n_chars;
    while (chars_pending.size() < target) make_random_string();
  endtask

  task automatic drain();
    while (chars_pending.size() != 0 || s_axis_tvalid_i || dates_expected.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_year_max(logic [ACC_W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    year_max = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------- sender ----------------

  always @(negedge clk_i) begin
    char_item_t nxt;
    if (!s_axis_tvalid_i || in_fire) begin
      if (chars_pending.size() != 0 && (no_idle || $urandom_range(0, 99) >= 36)) begin
        nxt = chars_pending.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= nxt.ch;
        s_axis_tlast_i <= nxt.last;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // ---------------- receiver ----------------

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= HOLD_CYCLES;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= no_idle || ($urandom_range(0, 99) >= 36);
    end
  end

  always @(posedge clk_i) begin
    date_res_t got;
    date_res_t want;
    in_fire <= rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      predict_char(s_axis_tdata_i, s_axis_tlast_i);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (dates_expected.size() == 0) begin
        log_mismatch("result with nothing pending", '0, got);
      end else begin
        want = dates_expected.pop_front();
        if (got.ok !== want.ok || got.day !== want.day ||
            got.month !== want.month || got.year !== want.year)
          log_mismatch("date result", want, got);
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    logic [ACC_W-1:0] year_plan[7];
    year_plan = '{14'd9999, 14'd1, 14'd0, 14'd16383,
                  14'($urandom_range(2, 9998)), YEAR_LIM_RST,
                  14'($urandom_range(10000, 16382))};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed strings at the reset value of the year limit
    add_text("29/2/1");           commit_string();
    add_text("30/2/1");           commit_string();
    add_text("31/4/5000");        commit_string();
    add_text("1/12/5001");        commit_string();
    add_text(" +7 /\t09 /1 ");    commit_string();
    add_text("-0/1/1");           commit_string();
    add_text("-2/1/1");           commit_string();
    add_text("1/-/1");            commit_string();
    add_text("1/+ 2/3");          commit_string();
    add_text("1/1/99999");        commit_string();
    add_text("1/1");
    str_buf.push_back(8'h00);
    add_text("/1");               commit_string();
    add_text("1/1/1/1");          commit_string();
    add_text("//3//3//3//");      commit_string();
    add_text("31/12/  ");         commit_string();
    add_text("x");                commit_string();
    drain();

    foreach (year_plan[i]) begin
      write_year_max(year_plan[i]);
      // phase 1 runs without gaps, phase 3 also stalls the result side for a while
      no_idle = (i == 1) || (i == 3);
      fill_random(200);
      if (i == 3) hold_req = 1'b1;
      drain();
    end

    mismatches += dates_expected.size();
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: date_string_parser_core.f
rtl/core/dsp_pkg.sv
rtl/core/date_string_parser_core.sv
dv/tb_date_string_parser_core.sv
